// ===== hw/rtl/fnc_pkg.sv =====
// Firing node controller: shared codes, defaults and control types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fnc_pkg;

   // Default number of firing outputs
   localparam int OUTPUT_COUNT_DEF = 4;

   // Field widths
   localparam int THR_W   = 12;
   localparam int CNT_W   = 16;
   localparam int VALUE_W = 8;
   localparam int VIS_W   = 4;   // outputs visible on the result item

   // Item action codes
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_SAMPLE = 2'd1;
   localparam logic [1:0] ACT_MSG    = 2'd2;

   // Message kinds
   localparam logic [1:0] KIND_PING = 2'd0;
   localparam logic [1:0] KIND_SET  = 2'd1;
   localparam logic [1:0] KIND_GET  = 2'd2;

   // Message tags
   localparam logic [1:0] TAG_ARM    = 2'd0;
   localparam logic [1:0] TAG_FIRE   = 2'd1;
   localparam logic [1:0] TAG_STATUS = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_OPEN_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_PULSE_TICKS    = 2'd1;
   localparam logic [1:0] CSR_CHECK_TICKS    = 2'd2;
   localparam logic [1:0] CSR_LINK_TICKS     = 2'd3;

   // Register reset values
   localparam logic [THR_W-1:0] OPEN_THRESHOLD_RST = 12'd2048;
   localparam logic [CNT_W-1:0] PULSE_TICKS_RST    = 16'd1000;
   localparam logic [CNT_W-1:0] CHECK_TICKS_RST    = 16'd200;
   localparam logic [CNT_W-1:0] LINK_TICKS_RST     = 16'd2500;
   localparam logic [VIS_W-1:0] OPEN_BITS_RST      = 4'hF;

   // Control from the item decode to the pulse timers
   typedef struct packed {
      logic               tick;       // count down active pulses
      logic               clear_all;  // disarm: drop all outputs
      logic               fire;       // start a pulse
      logic [VALUE_W-1:0] fire_index;
   } pulse_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fnc_pulse_bank.sv =====
// Firing node controller: per-output pulse timers and drive bits.
// Depends on fnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnc_pulse_bank
   import fnc_pkg::*;
#(
   parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pulse_ctl_type           ctl,
   input  wire logic [CNT_W-1:0]        pulse_ticks,
   output logic      [OUTPUT_COUNT-1:0] drive_next
);

   logic [CNT_W-1:0]        pulse_count_ff [OUTPUT_COUNT];
   logic [CNT_W-1:0]        pulse_count_in [OUTPUT_COUNT];
   logic [OUTPUT_COUNT-1:0] drive_ff;
   logic [OUTPUT_COUNT-1:0] drive_in;

   // One timer per output; fire wins over the tick for its own output
   always_comb begin
      for (int k = 0; k < OUTPUT_COUNT; k++) begin
         drive_in[k]       = drive_ff[k];
         pulse_count_in[k] = pulse_count_ff[k];
         if (ctl.tick && drive_ff[k]) begin
            if (pulse_count_ff[k] == '0) begin
               drive_in[k] = 1'b0;
            end else begin
               pulse_count_in[k] = pulse_count_ff[k] - 1'b1;
            end
         end
         if (ctl.clear_all) begin
            drive_in[k]       = 1'b0;
            pulse_count_in[k] = '0;
         end
         if (ctl.fire && ctl.fire_index == VALUE_W'(k)) begin
            drive_in[k]       = 1'b1;
            pulse_count_in[k] = pulse_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= '0;
      end else begin
         drive_ff <= drive_in;
      end
   end

   // Counts only matter while their drive bit is set
   always_ff @(posedge clock) begin
      for (int k = 0; k < OUTPUT_COUNT; k++) begin
         pulse_count_ff[k] <= pulse_count_in[k];
      end
   end

   assign drive_next = drive_in;

endmodule

`default_nettype wire

// ===== hw/rtl/firing_node_controller.sv =====
// Firing node controller top level: item decode, arm/link/scan state, result register.
// Depends on fnc_pkg and fnc_pulse_bank.
//
//  channel | dir | handshake              | payload
//  req_    | in  | req_valid / req_ready  | action, adc_sample, msg_kind, msg_tag, msg_value
//  rsp_    | out | rsp_valid / rsp_ready  | outputs_on, is_armed, is_connected, open_mask,
//          |     |                        | reply_valid, sample_request, sample_channel
//  csr_    | in  | csr_valid / csr_ready  | csr_index, csr_data (always ready)
//
// An item is registered on accept and its result is registered as the item advances:
// one item per cycle sustained while results are taken. The input register and the
// result register part the two sides, so a new item is taken while a result waits.
// A stalled result holds the pipe only when both registers are full.
// Reset clears the valid flags, node state and drive bits and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module firing_node_controller
   import fnc_pkg::*;
#(
   parameter int OUTPUT_COUNT = OUTPUT_COUNT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input items
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic [THR_W-1:0]   req_adc_sample,
   input  wire logic [1:0]         req_msg_kind,
   input  wire logic [1:0]         req_msg_tag,
   input  wire logic [VALUE_W-1:0] req_msg_value,
   // result items
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [VIS_W-1:0]        rsp_outputs_on,
   output logic                    rsp_is_armed,
   output logic                    rsp_is_connected,
   output logic [VIS_W-1:0]        rsp_open_mask,
   output logic                    rsp_reply_valid,
   output logic                    rsp_sample_request,
   output logic [1:0]              rsp_sample_channel,
   // configuration
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [CNT_W-1:0]   csr_data
);

   // Configuration registers
   logic [THR_W-1:0] open_threshold_ff;
   logic [CNT_W-1:0] pulse_ticks_ff;
   logic [CNT_W-1:0] check_ticks_ff;
   logic [CNT_W-1:0] link_ticks_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_threshold_ff <= OPEN_THRESHOLD_RST;
         pulse_ticks_ff    <= PULSE_TICKS_RST;
         check_ticks_ff    <= CHECK_TICKS_RST;
         link_ticks_ff     <= LINK_TICKS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OPEN_THRESHOLD: open_threshold_ff <= csr_data[THR_W-1:0];
            CSR_PULSE_TICKS:    pulse_ticks_ff    <= csr_data;
            CSR_CHECK_TICKS:    check_ticks_ff    <= csr_data;
            CSR_LINK_TICKS:     link_ticks_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register
   logic               in_valid_ff;
   logic [1:0]         action_ff;
   logic [THR_W-1:0]   adc_sample_ff;
   logic [1:0]         msg_kind_ff;
   logic [1:0]         msg_tag_ff;
   logic [VALUE_W-1:0] msg_value_ff;
   logic               advance;
   logic               rsp_valid_ff;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         action_ff     <= req_action;
         adc_sample_ff <= req_adc_sample;
         msg_kind_ff   <= req_msg_kind;
         msg_tag_ff    <= req_msg_tag;
         msg_value_ff  <= req_msg_value;
      end
   end

   // Node state
   logic             armed_ff, armed_in;
   logic             connected_ff, connected_in;
   logic [VIS_W-1:0] open_bits_ff, open_bits_in;
   logic [1:0]       scan_channel_ff, scan_channel_in;
   logic [CNT_W-1:0] check_count_ff, check_count_in;
   logic [CNT_W-1:0] link_count_ff, link_count_in;
   logic             reply_in;
   logic             request_in;
   pulse_ctl_type    pulse_ctl;

   // Item decode and state update
   always_comb begin
      armed_in        = armed_ff;
      connected_in    = connected_ff;
      open_bits_in    = open_bits_ff;
      scan_channel_in = scan_channel_ff;
      check_count_in  = check_count_ff;
      link_count_in   = link_count_ff;
      reply_in        = 1'b0;
      request_in      = 1'b0;
      pulse_ctl       = '0;
      pulse_ctl.fire_index = msg_value_ff;
      case (action_ff)
         ACT_TICK: begin
            pulse_ctl.tick = 1'b1;
            if (check_count_ff == '0) begin
               if (!armed_ff) begin
                  request_in     = 1'b1;
                  check_count_in = check_ticks_ff;
               end
            end else begin
               check_count_in = check_count_ff - 1'b1;
            end
            // link loss disarms but leaves outputs running
            if (link_count_ff == '0) begin
               armed_in     = 1'b0;
               connected_in = 1'b0;
            end else begin
               link_count_in = link_count_ff - 1'b1;
            end
         end
         ACT_SAMPLE: begin
            open_bits_in[scan_channel_ff] = (adc_sample_ff < open_threshold_ff);
            scan_channel_in = scan_channel_ff + 1'b1;
         end
         ACT_MSG: begin
            case (msg_kind_ff)
               KIND_PING: begin
                  link_count_in = link_ticks_ff;
                  armed_in      = 1'b1;
               end
               KIND_SET: begin
                  link_count_in = link_ticks_ff;
                  if (msg_tag_ff == TAG_ARM) begin
                     armed_in            = (msg_value_ff != '0);
                     pulse_ctl.clear_all = (msg_value_ff == '0);
                  end else if (msg_tag_ff == TAG_FIRE) begin
                     pulse_ctl.fire = 1'b1;
                  end
               end
               KIND_GET: begin
                  link_count_in = link_ticks_ff;
                  if (msg_tag_ff == TAG_STATUS) begin
                     reply_in     = 1'b1;
                     connected_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (!advance) begin
         pulse_ctl = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff        <= 1'b0;
         connected_ff    <= 1'b0;
         open_bits_ff    <= OPEN_BITS_RST;
         scan_channel_ff <= '0;
         check_count_ff  <= '0;
         link_count_ff   <= '0;
      end else if (advance) begin
         armed_ff        <= armed_in;
         connected_ff    <= connected_in;
         open_bits_ff    <= open_bits_in;
         scan_channel_ff <= scan_channel_in;
         check_count_ff  <= check_count_in;
         link_count_ff   <= link_count_in;
      end
   end

   // Output pulse timers
   logic [OUTPUT_COUNT-1:0] drive_next;
   logic [VIS_W-1:0]        outs_in;

   fnc_pulse_bank #(
      .OUTPUT_COUNT(OUTPUT_COUNT)
   ) u_pulse_bank (
      .clock      (clock),
      .reset      (reset),
      .ctl        (pulse_ctl),
      .pulse_ticks(pulse_ticks_ff),
      .drive_next (drive_next)
   );

   // Only the first four outputs are visible
   always_comb begin
      outs_in = '0;
      for (int k = 0; k < VIS_W; k++) begin
         if (k < OUTPUT_COUNT) begin
            outs_in[k] = drive_next[k];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_outputs_on     <= outs_in;
         rsp_is_armed       <= armed_in;
         rsp_is_connected   <= connected_in;
         rsp_open_mask      <= open_bits_in;
         rsp_reply_valid    <= reply_in;
         rsp_sample_request <= request_in;
         rsp_sample_channel <= scan_channel_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fnc_checker.sv =====
// Firing node controller: port-level assertions, bound to the top level.
// Depends on fnc_pkg and firing_node_controller.
`timescale 1ns / 1ps
`default_nettype none

module fnc_checker
   import fnc_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [VIS_W-1:0]   rsp_outputs_on,
   input wire logic               rsp_is_armed,
   input wire logic               rsp_is_connected,
   input wire logic [VIS_W-1:0]   rsp_open_mask,
   input wire logic               rsp_reply_valid,
   input wire logic               rsp_sample_request,
   input wire logic [1:0]         rsp_sample_channel
);

   // A waiting result item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_open_mask)
         && $stable(rsp_is_armed) && $stable(rsp_outputs_on)
         && $stable(rsp_is_connected) && $stable(rsp_reply_valid)
         && $stable(rsp_sample_request) && $stable(rsp_sample_channel))
      else $error("result item changed while stalled");

   // Status reply only comes with the link marked up
   a_reply_conn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_valid |-> rsp_is_connected)
      else $error("reply without connected flag");

   // Continuity checks are only requested while disarmed
   a_req_disarmed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_request |-> !rsp_is_armed && !rsp_reply_valid)
      else $error("sample request while armed");

   // No result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind firing_node_controller fnc_checker u_fnc_checker (.*);

`default_nettype wire

// ===== verif/tb_firing_node_controller.sv =====
// Self-checking testbench for firing_node_controller: directed probe table, then
// randomized phases under several register settings. Depends on fnc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_firing_node_controller;
   import fnc_pkg::*;

   localparam int NOUT          = OUTPUT_COUNT_DEF;
   localparam int PROBE_ROWS    = 24;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 213;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int SHOW_LIMIT    = 10;

   // Codes the package leaves unnamed
   localparam logic [1:0] ACT_NONE   = 2'd3;
   localparam logic [1:0] KIND_OTHER = 2'd3;
   localparam logic [1:0] TAG_OTHER  = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [THR_W-1:0]   sample;
      logic [1:0]         kind;
      logic [1:0]         tag;
      logic [VALUE_W-1:0] value;
   } node_item_type;

   typedef struct packed {
      logic [VIS_W-1:0] outputs_on;
      logic             armed;
      logic             connected;
      logic [VIS_W-1:0] open_mask;
      logic             reply;
      logic             request;
      logic [1:0]       channel;
   } node_status_type;

   typedef struct packed {
      node_item_type   item;
      logic            given;   // status below is typed in, not predicted
      node_status_type want;
   } probe_row_type;

   localparam node_status_type NO_WANT = '0;

   // DUT ports
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = ACT_TICK;
   logic [THR_W-1:0]   req_adc_sample = '0;
   logic [1:0]         req_msg_kind = KIND_PING;
   logic [1:0]         req_msg_tag = TAG_ARM;
   logic [VALUE_W-1:0] req_msg_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [VIS_W-1:0]   rsp_outputs_on;
   logic               rsp_is_armed;
   logic               rsp_is_connected;
   logic [VIS_W-1:0]   rsp_open_mask;
   logic               rsp_reply_valid;
   logic               rsp_sample_request;
   logic [1:0]         rsp_sample_channel;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_OPEN_THRESHOLD;
   logic [CNT_W-1:0]   csr_data = '0;

   // Predicted node state and register copies
   logic               node_armed;
   logic               link_up;
   logic [VIS_W-1:0]   open_nibble;
   logic [1:0]         scan_ch;
   logic [CNT_W-1:0]   check_left;
   logic [CNT_W-1:0]   link_left;
   logic [CNT_W-1:0]   pulse_left [NOUT];
   logic [NOUT-1:0]    out_drive;
   logic [THR_W-1:0]   thr_cfg;
   logic [CNT_W-1:0]   pulse_cfg;
   logic [CNT_W-1:0]   check_cfg;
   logic [CNT_W-1:0]   link_cfg;

   node_status_type    status_q [$];
   int                 fail_count = 0;
   int                 rsp_count = 0;
   int                 samples_owed = 0;
   int                 idle_cycles = 0;
   logic               src_quiet = 1'b0;
   logic               sink_quiet = 1'b0;

   // Directed probes, run at reset register values
   probe_row_type probe_rows [PROBE_ROWS] = '{
      // first tick after reset: check request on channel 0, link already expired
      '{'{ACT_TICK, 12'd0, KIND_PING, TAG_ARM, 8'd0}, 1'b1,
        '{4'h0, 1'b0, 1'b0, 4'hF, 1'b0, 1'b1, 2'd0}},
      // samples at the extremes and either side of the threshold
      '{'{ACT_SAMPLE, 12'd0, KIND_PING, TAG_ARM, 8'd0}, 1'b1,
        '{4'h0, 1'b0, 1'b0, 4'hF, 1'b0, 1'b0, 2'd1}},
      '{'{ACT_SAMPLE, 12'd4095, KIND_PING, TAG_ARM, 8'd0}, 1'b1,
        '{4'h0, 1'b0, 1'b0, 4'hD, 1'b0, 1'b0, 2'd2}},
      '{'{ACT_SAMPLE, 12'd2048, KIND_PING, TAG_ARM, 8'd0}, 1'b1,
        '{4'h0, 1'b0, 1'b0, 4'h9, 1'b0, 1'b0, 2'd3}},
      '{'{ACT_SAMPLE, 12'd2047, KIND_PING, TAG_ARM, 8'd0}, 1'b1,
        '{4'h0, 1'b0, 1'b0, 4'h9, 1'b0, 1'b0, 2'd0}},
      // status request connects, ping arms
      '{'{ACT_MSG, 12'd0, KIND_GET, TAG_STATUS, 8'd0}, 1'b1,
        '{4'h0, 1'b0, 1'b1, 4'h9, 1'b1, 1'b0, 2'd0}},
      '{'{ACT_MSG, 12'd0, KIND_PING, TAG_ARM, 8'd0}, 1'b1,
        '{4'h0, 1'b1, 1'b1, 4'h9, 1'b0, 1'b0, 2'd0}},
      // fire lowest and highest output, then out-of-range indexes
      '{'{ACT_MSG, 12'd0, KIND_SET, TAG_FIRE, 8'd0}, 1'b1,
        '{4'h1, 1'b1, 1'b1, 4'h9, 1'b0, 1'b0, 2'd0}},
      '{'{ACT_MSG, 12'd0, KIND_SET, TAG_FIRE, 8'd3}, 1'b1,
        '{4'h9, 1'b1, 1'b1, 4'h9, 1'b0, 1'b0, 2'd0}},
      '{'{ACT_MSG, 12'd0, KIND_SET, TAG_FIRE, 8'd4}, 1'b1,
        '{4'h9, 1'b1, 1'b1, 4'h9, 1'b0, 1'b0, 2'd0}},
      '{'{ACT_MSG, 12'd0, KIND_SET, TAG_FIRE, 8'd255}, 1'b1,
        '{4'h9, 1'b1, 1'b1, 4'h9, 1'b0, 1'b0, 2'd0}},
      '{'{ACT_TICK, 12'd0, KIND_PING, TAG_ARM, 8'd0}, 1'b0, NO_WANT},
      // sample while armed and unrequested
      '{'{ACT_SAMPLE, 12'd4095, KIND_PING, TAG_ARM, 8'd0}, 1'b0, NO_WANT},
      // unused kind and tags
      '{'{ACT_MSG, 12'd0, KIND_OTHER, TAG_ARM, 8'd0}, 1'b0, NO_WANT},
      '{'{ACT_MSG, 12'd0, KIND_SET, TAG_OTHER, 8'hAA}, 1'b0, NO_WANT},
      '{'{ACT_MSG, 12'd0, KIND_GET, TAG_ARM, 8'h55}, 1'b0, NO_WANT},
      '{'{ACT_MSG, 12'd0, KIND_SET, TAG_ARM, 8'd1}, 1'b0, NO_WANT},
      // disarm drops outputs
      '{'{ACT_MSG, 12'd0, KIND_SET, TAG_ARM, 8'd0}, 1'b0, NO_WANT},
      '{'{ACT_NONE, 12'hFFF, KIND_OTHER, TAG_OTHER, 8'hFF}, 1'b0, NO_WANT},
      '{'{ACT_MSG, 12'd0, KIND_SET, TAG_ARM, 8'd128}, 1'b0, NO_WANT},
      '{'{ACT_MSG, 12'd0, KIND_GET, TAG_STATUS, 8'd0}, 1'b0, NO_WANT},
      '{'{ACT_TICK, 12'hFFF, KIND_OTHER, TAG_OTHER, 8'hFF}, 1'b0, NO_WANT},
      '{'{ACT_NONE, 12'd0, KIND_PING, TAG_ARM, 8'd0}, 1'b0, NO_WANT},
      '{'{ACT_MSG, 12'd0, KIND_SET, TAG_FIRE, 8'd1}, 1'b0, NO_WANT}
   };

   firing_node_controller i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_adc_sample     (req_adc_sample),
      .req_msg_kind       (req_msg_kind),
      .req_msg_tag        (req_msg_tag),
      .req_msg_value      (req_msg_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_outputs_on     (rsp_outputs_on),
      .rsp_is_armed       (rsp_is_armed),
      .rsp_is_connected   (rsp_is_connected),
      .rsp_open_mask      (rsp_open_mask),
      .rsp_reply_valid    (rsp_reply_valid),
      .rsp_sample_request (rsp_sample_request),
      .rsp_sample_channel (rsp_sample_channel),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #4 clock = ~clock;

   // Node state after reset
   task automatic reset_node();
      int k;
      node_armed  = 1'b0;
      link_up     = 1'b0;
      open_nibble = OPEN_BITS_RST;
      scan_ch     = 2'd0;
      check_left  = '0;
      link_left   = '0;
      out_drive   = '0;
      for (k = 0; k < NOUT; k++) pulse_left[k] = '0;
      thr_cfg   = OPEN_THRESHOLD_RST;
      pulse_cfg = PULSE_TICKS_RST;
      check_cfg = CHECK_TICKS_RST;
      link_cfg  = LINK_TICKS_RST;
   endtask

   // Advance the node by one item and return its status
   function automatic node_status_type step_node(input node_item_type it);
      node_status_type st;
      int k;
      st = '0;
      case (it.action)
         ACT_TICK: begin
            // continuity check timer runs even while armed
            if (check_left == '0) begin
               if (!node_armed) begin
                  st.request = 1'b1;
                  check_left = check_cfg;
               end
            end else begin
               check_left = check_left - 1'b1;
            end
            // expired link disarms on every tick but keeps outputs
            if (link_left == '0) begin
               node_armed = 1'b0;
               link_up    = 1'b0;
            end else begin
               link_left = link_left - 1'b1;
            end
            for (k = 0; k < NOUT; k++) begin
               if (out_drive[k]) begin
                  if (pulse_left[k] == '0) out_drive[k] = 1'b0;
                  else pulse_left[k] = pulse_left[k] - 1'b1;
               end
            end
         end
         ACT_SAMPLE: begin
            open_nibble[scan_ch] = (it.sample < thr_cfg);
            scan_ch = scan_ch + 2'd1;
         end
         ACT_MSG: begin
            if (it.kind != KIND_OTHER) link_left = link_cfg;
            case (it.kind)
               KIND_PING: node_armed = 1'b1;
               KIND_SET: begin
                  if (it.tag == TAG_ARM) begin
                     node_armed = (it.value != '0);
                     if (it.value == '0) begin
                        out_drive = '0;
                        for (k = 0; k < NOUT; k++) pulse_left[k] = '0;
                     end
                  end else if (it.tag == TAG_FIRE && int'(it.value) < NOUT) begin
                     out_drive[it.value] = 1'b1;
                     pulse_left[it.value] = pulse_cfg;
                  end
               end
               KIND_GET: begin
                  if (it.tag == TAG_STATUS) begin
                     st.reply = 1'b1;
                     link_up  = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      for (k = 0; k < VIS_W; k++)
         if (k < NOUT) st.outputs_on[k] = out_drive[k];
      st.armed     = node_armed;
      st.connected = link_up;
      st.open_mask = open_nibble;
      st.channel   = scan_ch;
      return st;
   endfunction

   // Random item, mostly samples answering requests, ticks and useful messages
   function automatic node_item_type draw_item();
      node_item_type it;
      int pick;
      int level;
      it.action = ACT_TICK;
      it.sample = 12'($urandom_range(0, 4095));
      it.kind   = 2'($urandom_range(0, 3));
      it.tag    = 2'($urandom_range(0, 3));
      it.value  = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (samples_owed > 0 && $urandom_range(0, 9) < 7) begin
         samples_owed--;
         pick = 50;
      end
      if (pick < 45) begin
         it.action = ACT_TICK;
      end else if (pick < 60) begin
         it.action = ACT_SAMPLE;
         if ($urandom_range(0, 1) == 0) begin
            level = int'(thr_cfg) + int'($urandom_range(0, 4)) - 2;
            if (level < 0) level = 0;
            if (level > 4095) level = 4095;
            it.sample = 12'(level);
         end
      end else if (pick < 96) begin
         it.action = ACT_MSG;
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            it.kind = KIND_PING;
         end else if (pick < 65) begin
            it.kind = KIND_SET;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               it.tag = TAG_ARM;
               if ($urandom_range(0, 1) == 0) it.value = '0;
            end else if (pick < 90) begin
               it.tag = TAG_FIRE;
               if ($urandom_range(0, 4) != 0) it.value = 8'($urandom_range(0, NOUT - 1));
            end else begin
               it.tag = 2'($urandom_range(2, 3));
            end
         end else if (pick < 95) begin
            it.kind = KIND_GET;
            if ($urandom_range(0, 4) != 0) it.tag = TAG_STATUS;
         end else begin
            it.kind = KIND_OTHER;
         end
      end else begin
         it.action = ACT_NONE;
      end
      return it;
   endfunction

   // Offer one item; predict its status once accepted
   task automatic send_item(input node_item_type it, input logic given,
                            input node_status_type typed);
      int gap;
      node_status_type pred;
      gap = src_quiet ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= it.action;
      req_adc_sample <= it.sample;
      req_msg_kind   <= it.kind;
      req_msg_tag    <= it.tag;
      req_msg_value  <= it.value;
      do @(posedge clock); while (!req_ready);
      pred = step_node(it);
      if (pred.request) samples_owed++;
      status_q.push_back(given ? typed : pred);
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_OPEN_THRESHOLD: thr_cfg   = data[THR_W-1:0];
         CSR_PULSE_TICKS:    pulse_cfg = data;
         CSR_CHECK_TICKS:    check_cfg = data;
         CSR_LINK_TICKS:     link_cfg  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stimulus
   initial begin : stimulus
      int r;
      int ph;
      int items;
      node_item_type it;
      logic [CNT_W-1:0] thr, pul, chk, lnk;
      reset_node();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < PROBE_ROWS; r++)
         send_item(probe_rows[r].item, probe_rows[r].given, probe_rows[r].want);

      for (ph = 0; ph < PHASES; ph++) begin
         drain_results();
         // register setting per phase: a short fixed setting, then extremes, then random short timers
         case (ph)
            0: begin thr = 16'd2048; pul = 16'd3;     chk = 16'd2;     lnk = 16'd12;    end
            1: begin thr = 16'd0;    pul = 16'd0;     chk = 16'd0;     lnk = 16'd0;     end
            2: begin thr = 16'd4095; pul = 16'hFFFF;  chk = 16'hFFFF;  lnk = 16'hFFFF;  end
            3: begin thr = 16'd1;    pul = 16'd1;     chk = 16'd1;     lnk = 16'd1;     end
            default: begin
               thr = 16'($urandom_range(0, 4095));
               pul = 16'($urandom_range(0, 10));
               chk = 16'($urandom_range(0, 8));
               lnk = 16'($urandom_range(0, 40));
            end
         endcase
         write_reg(CSR_OPEN_THRESHOLD, thr);
         write_reg(CSR_PULSE_TICKS, pul);
         write_reg(CSR_CHECK_TICKS, chk);
         write_reg(CSR_LINK_TICKS, lnk);
         items = 0;
         while (items < PHASE_ITEMS) begin
            it = draw_item();
            if (it.action != ACT_NONE) items++;
            send_item(it, 1'b0, NO_WANT);
            if ($urandom_range(0, 149) == 0) drain_results();
            if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (status_q.size() != 0) begin
         $display("%0d expected results never arrived", status_q.size());
         fail_count += status_q.size();
      end
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Result side: random stalls, compare each item against the oldest prediction
   initial begin : result_sink
      int stall;
      node_status_type got;
      node_status_type want;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         stall = sink_quiet ? 0 : $urandom_range(0, 3);
         if ($urandom_range(0, 49) == 0) sink_quiet = !sink_quiet;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = '{rsp_outputs_on, rsp_is_armed, rsp_is_connected, rsp_open_mask,
                 rsp_reply_valid, rsp_sample_request, rsp_sample_channel};
         if (status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
               $display("result %0d arrived with nothing expected", rsp_count);
         end else begin
            want = status_q.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT) begin
                  $display("result %0d (want/got): outs %h/%h armed %b/%b conn %b/%b",
                           rsp_count, want.outputs_on, got.outputs_on, want.armed,
                           got.armed, want.connected, got.connected);
                  $display("   open %h/%h reply %b/%b request %b/%b channel %0d/%0d",
                           want.open_mask, got.open_mask, want.reply, got.reply,
                           want.request, got.request, want.channel, got.channel);
               end
            end
         end
         rsp_count++;
      end
   end

   // Watchdog: too long without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
